[hdl/slpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slpd_pkg;

  // Committed byte store.
  localparam int unsigned STORE_DEPTH = 2048;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  // Pointers and the committed count must hold STORE_DEPTH itself.
  localparam int unsigned CNT_W       = STORE_AW + 1;

  // Staging buffer for the packet in progress: sync byte, length byte, up to 256 bytes.
  localparam int unsigned HEADER_BYTES = 2;
  localparam int unsigned MAX_PAYLOAD  = 256;
  localparam int unsigned STAGE_SIZE   = HEADER_BYTES + MAX_PAYLOAD;
  localparam int unsigned STAGE_AW     = $clog2(STAGE_SIZE);
  localparam int unsigned LEN_W        = $clog2(STAGE_SIZE + 1);

  localparam int unsigned MAX_READ     = 64;
  localparam int unsigned RCNT_W       = 7;
  localparam int unsigned PEND_W       = 12;

  localparam logic [7:0] SYNC_RESET    = 8'h55;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

endpackage

`default_nettype wire

[hdl/slpd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module slpd_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/sync_length_packet_deframer_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// input     start / busy              in_kind, in_rx_byte, in_read_count
// result    out_strobe (one cycle)    out_data_byte, out_data_valid, out_last,
//                                     out_pending_count, out_overflow
// config    cfg_valid / cfg_ready     cfg_sync_code
//
// A link byte is taken without raising busy. The byte that completes a packet starts a
// copy from the staging RAM into the byte store at one byte per cycle, header bytes
// included, and busy stays high until the copy is done.
// A read that pops N bytes keeps busy high while it makes one store read per cycle;
// an empty read leaves busy low. Results are registered at the store and at the output.
// Reset is synchronous and clears the control state only; the store is not cleared and
// only committed entries are ever read. The receiver cannot stall the result channel.

module sync_length_packet_deframer_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_kind,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic [slpd_pkg::RCNT_W-1:0]    in_read_count,
  output logic                                out_strobe,
  output logic      [7:0]                     out_data_byte,
  output logic                                out_data_valid,
  output logic                                out_last,
  output logic      [slpd_pkg::PEND_W-1:0]    out_pending_count,
  output logic                                out_overflow,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [7:0]                     cfg_sync_code
);

  localparam int unsigned AW   = slpd_pkg::STORE_AW;
  localparam int unsigned CW   = slpd_pkg::CNT_W;
  localparam int unsigned SAW  = slpd_pkg::STAGE_AW;
  localparam int unsigned LW   = slpd_pkg::LEN_W;
  localparam int unsigned RW   = slpd_pkg::RCNT_W;
  localparam int unsigned PW   = slpd_pkg::PEND_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_READ
  } state_t;

  state_t         state_r, state_nxt;
  logic [7:0]     sync_r, sync_nxt;
  logic [CW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cp_r, cp_nxt;
  logic [CW-1:0]  committed_r, committed_nxt;
  logic [LW-1:0]  staged_r, staged_nxt;
  logic [LW-1:0]  plen_r, plen_nxt;
  logic           ovr_r, ovr_nxt;
  logic           ovf_hold_r, ovf_hold_nxt;
  logic [RW-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]  copy_idx_r, copy_idx_nxt;

  logic           p1_strobe_r, p1_strobe_nxt;
  logic           p1_valid_r, p1_valid_nxt;
  logic           p1_last_r, p1_last_nxt;
  logic [PW-1:0]  p1_pending_r, p1_pending_nxt;
  logic           p1_ovf_r, p1_ovf_nxt;

  logic           out_strobe_r;
  logic [7:0]     out_data_byte_r;
  logic           out_data_valid_r;
  logic           out_last_r;
  logic [PW-1:0]  out_pending_r;
  logic           out_overflow_r;

  logic           accept;
  logic [RW-1:0]  want;
  logic [RW-1:0]  count;
  logic [CW:0]    end_sum;
  logic [LW-1:0]  staged_inc;

  logic           stg_we, stg_re;
  logic [SAW-1:0] stg_waddr, stg_raddr;
  logic [7:0]     stg_rdata;
  logic           st_we, st_re;
  logic [AW-1:0]  st_waddr, st_raddr;
  logic [7:0]     st_rdata;

  slpd_ram #(
    .DEPTH (slpd_pkg::STAGE_SIZE),
    .WIDTH (8)
  ) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (in_rx_byte),
    .re    (stg_re),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  slpd_ram #(
    .DEPTH (slpd_pkg::STORE_DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (stg_rdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  assign want  = (in_read_count > RW'(slpd_pkg::MAX_READ)) ? RW'(slpd_pkg::MAX_READ)
                                                           : in_read_count;
  assign count = (committed_r < CW'(want)) ? RW'(committed_r) : want;
  assign end_sum    = {1'b0, cp_r} + (CW + 1)'(plen_r);
  assign staged_inc = staged_r + LW'(1);

  always_comb begin
    state_nxt      = state_r;
    sync_nxt       = cfg_valid ? cfg_sync_code : sync_r;
    rp_nxt         = rp_r;
    cp_nxt         = cp_r;
    committed_nxt  = committed_r;
    staged_nxt     = staged_r;
    plen_nxt       = plen_r;
    ovr_nxt        = ovr_r;
    ovf_hold_nxt   = ovf_hold_r;
    cnt_nxt        = cnt_r;
    copy_idx_nxt   = copy_idx_r;

    p1_strobe_nxt  = 1'b0;
    p1_valid_nxt   = 1'b0;
    p1_last_nxt    = 1'b0;
    p1_pending_nxt = p1_pending_r;
    p1_ovf_nxt     = p1_ovf_r;

    stg_we    = 1'b0;
    stg_waddr = SAW'(staged_r);
    stg_re    = 1'b0;
    stg_raddr = SAW'(copy_idx_r);
    st_we     = 1'b0;
    st_waddr  = cp_r[AW-1:0] + AW'(copy_idx_r) - AW'(1);
    st_re     = 1'b0;
    st_raddr  = rp_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == slpd_pkg::KIND_BYTE) begin
          if (staged_r == '0) begin
            if (in_rx_byte == sync_r) begin
              stg_we     = 1'b1;
              staged_nxt = LW'(1);
            end
          end else if (staged_r == LW'(1)) begin
            stg_we     = 1'b1;
            staged_nxt = LW'(2);
            plen_nxt   = LW'(slpd_pkg::HEADER_BYTES) +
                         ((in_rx_byte == 8'd0) ? LW'(slpd_pkg::MAX_PAYLOAD) : LW'(in_rx_byte));
          end else begin
            stg_we     = 1'b1;
            staged_nxt = staged_inc;
            if (staged_inc >= plen_r) begin
              staged_nxt = '0;
              // A packet that would run past the end of the store is dropped whole.
              if (end_sum > (CW + 1)'(slpd_pkg::STORE_DEPTH)) begin
                ovr_nxt  = 1'b1;
                plen_nxt = '0;
              end else begin
                copy_idx_nxt = '0;
                state_nxt    = ST_COPY;
              end
            end
          end
        end else if (accept) begin
          ovr_nxt = 1'b0;
          if (count == '0) begin
            p1_strobe_nxt  = 1'b1;
            p1_valid_nxt   = 1'b0;
            p1_last_nxt    = 1'b1;
            p1_pending_nxt = PW'(committed_r);
            p1_ovf_nxt     = ovr_r;
          end else begin
            cnt_nxt      = count;
            ovf_hold_nxt = ovr_r;
            state_nxt    = ST_READ;
          end
        end
      end

      ST_COPY: begin
        // The staging RAM read of one cycle feeds the store write of the next.
        stg_re = (copy_idx_r < plen_r);
        st_we  = (copy_idx_r != '0);
        if (copy_idx_r == plen_r) begin
          cp_nxt        = cp_r + CW'(plen_r);
          committed_nxt = cp_r + CW'(plen_r) - rp_r;
          plen_nxt      = '0;
          state_nxt     = ST_IDLE;
        end else begin
          copy_idx_nxt = copy_idx_r + LW'(1);
        end
      end

      ST_READ: begin
        st_re          = 1'b1;
        p1_strobe_nxt  = 1'b1;
        p1_valid_nxt   = 1'b1;
        p1_last_nxt    = (cnt_r == RW'(1));
        p1_pending_nxt = PW'(committed_r - CW'(1));
        p1_ovf_nxt     = ovf_hold_r;
        rp_nxt         = rp_r + CW'(1);
        committed_nxt  = committed_r - CW'(1);
        cnt_nxt        = cnt_r - RW'(1);
        if (cnt_r == RW'(1)) begin
          state_nxt = ST_IDLE;
        end
        // Once the store runs empty both pointers return to the start.
        if (committed_r == CW'(1)) begin
          rp_nxt = '0;
          cp_nxt = '0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sync_r       <= slpd_pkg::SYNC_RESET;
      rp_r         <= '0;
      cp_r         <= '0;
      committed_r  <= '0;
      staged_r     <= '0;
      plen_r       <= '0;
      ovr_r        <= 1'b0;
      p1_strobe_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sync_r       <= sync_nxt;
      rp_r         <= rp_nxt;
      cp_r         <= cp_nxt;
      committed_r  <= committed_nxt;
      staged_r     <= staged_nxt;
      plen_r       <= plen_nxt;
      ovr_r        <= ovr_nxt;
      p1_strobe_r  <= p1_strobe_nxt;
      out_strobe_r <= p1_strobe_r;
    end
  end

  always_ff @(posedge clk) begin
    ovf_hold_r       <= ovf_hold_nxt;
    cnt_r            <= cnt_nxt;
    copy_idx_r       <= copy_idx_nxt;
    p1_valid_r       <= p1_valid_nxt;
    p1_last_r        <= p1_last_nxt;
    p1_pending_r     <= p1_pending_nxt;
    p1_ovf_r         <= p1_ovf_nxt;
    out_data_byte_r  <= p1_valid_r ? st_rdata : 8'd0;
    out_data_valid_r <= p1_valid_r;
    out_last_r       <= p1_last_r;
    out_pending_r    <= p1_pending_r;
    out_overflow_r   <= p1_ovf_r;
  end

  assign out_strobe        = out_strobe_r;
  assign out_data_byte     = out_data_byte_r;
  assign out_data_valid    = out_data_valid_r;
  assign out_last          = out_last_r;
  assign out_pending_count = out_pending_r;
  assign out_overflow      = out_overflow_r;

  a_count_tracks_pointers: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r == cp_r - rp_r)
    else $error("committed count disagrees with the pointers");

  a_commit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cp_r <= CW'(slpd_pkg::STORE_DEPTH))
    else $error("commit pointer passed the end of the store");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data_valid |-> out_last && out_data_byte == 8'd0)
    else $error("invalid result not marked last or carries data");

  a_read_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> committed_r != '0 && cnt_r != '0)
    else $error("pop issued with nothing committed");

endmodule

`default_nettype wire
